// ----- hdl/rmth_pkg.sv -----
// shared constants and types for the running median block
`timescale 1ns / 1ps
package rmth_pkg;

    localparam int CAPACITY    = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int HEAP_DEPTH  = (CAPACITY + 1) / 2;
    localparam int IDX_BITS    = $clog2(HEAP_DEPTH);
    localparam int SIZE_BITS   = $clog2(HEAP_DEPTH + 1);
    localparam int CNT_BITS    = 11;
    localparam int VAL_BITS    = 32;
    localparam int MED_BITS    = 33;

    // heap select codes
    localparam logic HEAP_LOWER = 1'b0;
    localparam logic HEAP_UPPER = 1'b1;

    typedef logic signed [VAL_BITS-1:0] val_t;
    typedef logic [IDX_BITS-1:0]        idx_t;
    typedef logic [SIZE_BITS-1:0]       size_t;

    // ordering test: max-heap for the lower half, min-heap for the upper half
    function automatic logic above(input val_t a, input val_t b, input logic heap);
        logic r;
        if (heap == HEAP_LOWER)
        begin
            r = (a > b);
        end
        else
        begin
            r = (a < b);
        end
        return r;
    endfunction

endpackage

// ----- hdl/rmth_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module rmth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/running_median_two_heaps_top.sv -----
// running median over two heaps held in rams
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, sample                 | request in
//  out     | out_valid, out_stall, median_x2,           | request out
//          | sample_count, dropped                      |
//
// one request at a time: a push walks up a 512-entry heap through a read state
// and an evaluate state per level, and a top replacement walks down through a
// left read, a right read and an evaluate state per level; a dropped request
// skips both walks. the ram read latency sets the pace of each level.
// reset clears sizes and the last median; tops and heap rams need no clearing.
// a stalled result holds in the output register; the next request waits for it.
`timescale 1ns / 1ps
module running_median_two_heaps_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [31:0]                  sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rmth_pkg::MED_BITS-1:0] median_x2,
    output logic [rmth_pkg::CNT_BITS-1:0]       sample_count,
    output logic                                dropped
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_PUSH_RD = 3'd1;
    localparam logic [2:0] S_PUSH_EV = 3'd2;
    localparam logic [2:0] S_DN_RDL  = 3'd3;
    localparam logic [2:0] S_DN_RDR  = 3'd4;
    localparam logic [2:0] S_DN_EV   = 3'd5;
    localparam logic [2:0] S_RESULT  = 3'd6;
    localparam logic [2:0] S_OUT     = 3'd7;

    localparam int CHILD_BITS = rmth_pkg::SIZE_BITS + 1;

    logic [2:0]            state_reg, state_next;
    rmth_pkg::size_t       lsize_reg, lsize_next, usize_reg, usize_next;
    rmth_pkg::val_t        ltop_reg, ltop_next, utop_reg, utop_next;
    logic signed [rmth_pkg::MED_BITS-1:0] last_med_reg, last_med_next;
    logic                  heap_reg, heap_next;
    rmth_pkg::val_t        val_reg, val_next;
    rmth_pkg::idx_t        idx_reg, idx_next;
    rmth_pkg::size_t       rsize_reg, rsize_next;
    logic                  rep_pend_reg, rep_pend_next;
    logic                  rep_heap_reg, rep_heap_next;
    rmth_pkg::val_t        rep_val_reg, rep_val_next;
    rmth_pkg::val_t        lchild_reg, lchild_next;
    logic                  has_r_reg, has_r_next;
    logic                  drop_reg, drop_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [rmth_pkg::MED_BITS-1:0] out_med_reg, out_med_next;
    logic [rmth_pkg::CNT_BITS-1:0] out_cnt_reg, out_cnt_next;
    logic                  out_drop_reg, out_drop_next;

    logic                  wr_en;
    rmth_pkg::idx_t        wr_addr, rd_addr;
    rmth_pkg::val_t        wr_data, rd_data;
    logic [31:0]           rd_lower, rd_upper;
    logic [rmth_pkg::CNT_BITS-1:0] count;
    rmth_pkg::val_t        x;
    logic                  in_acc;
    logic [CHILD_BITS-1:0] lchild_idx, rchild_idx;
    rmth_pkg::val_t        best_val;
    rmth_pkg::idx_t        best_idx;

    // heap storage
    rmth_ram #(.WIDTH(rmth_pkg::VAL_BITS), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_lower_ram (
        .clk   (clk),
        .we    (wr_en && (heap_reg == rmth_pkg::HEAP_LOWER)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_lower)
    );

    rmth_ram #(.WIDTH(rmth_pkg::VAL_BITS), .DEPTH(rmth_pkg::HEAP_DEPTH)) u_upper_ram (
        .clk   (clk),
        .we    (wr_en && (heap_reg == rmth_pkg::HEAP_UPPER)),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_upper)
    );

    assign rd_data = (heap_reg == rmth_pkg::HEAP_LOWER) ? rd_lower : rd_upper;

    // handshake and small helpers
    assign in_stall     = (state_reg != S_IDLE);
    assign in_acc       = in_valid && !in_stall;
    assign count        = rmth_pkg::CNT_BITS'(lsize_reg) + rmth_pkg::CNT_BITS'(usize_reg);
    assign x            = rmth_pkg::VAL_BITS'($signed(sample[rmth_pkg::SAMPLE_BITS-1:0]));
    assign lchild_idx   = {1'b0, idx_reg, 1'b1};
    assign rchild_idx   = lchild_idx + CHILD_BITS'(1);
    assign out_valid    = out_valid_reg;
    assign median_x2    = out_med_reg;
    assign sample_count = out_cnt_reg;
    assign dropped      = out_drop_reg;

    // best child for the sift-down
    always_comb
    begin
        best_val = lchild_reg;
        best_idx = lchild_idx[rmth_pkg::IDX_BITS-1:0];
        if (has_r_reg && rmth_pkg::above(rd_data, lchild_reg, heap_reg))
        begin
            best_val = rd_data;
            best_idx = rchild_idx[rmth_pkg::IDX_BITS-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        lsize_next     = lsize_reg;
        usize_next     = usize_reg;
        last_med_next  = last_med_reg;
        heap_next      = heap_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        rsize_next     = rsize_reg;
        rep_pend_next  = rep_pend_reg;
        rep_heap_next  = rep_heap_reg;
        rep_val_next   = rep_val_reg;
        lchild_next    = lchild_reg;
        has_r_next     = has_r_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_med_next   = out_med_reg;
        out_cnt_next   = out_cnt_reg;
        out_drop_next  = out_drop_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = val_reg;
        rd_addr        = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    drop_next     = 1'b0;
                    rep_pend_next = 1'b0;
                    state_next    = S_PUSH_RD;
                    if (count >= rmth_pkg::CNT_BITS'(rmth_pkg::CAPACITY))
                    begin
                        drop_next  = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (lsize_reg > usize_reg)
                    begin
                        heap_next  = rmth_pkg::HEAP_UPPER;
                        idx_next   = usize_reg[rmth_pkg::IDX_BITS-1:0];
                        usize_next = usize_reg + rmth_pkg::SIZE_BITS'(1);
                        if (x < ltop_reg)
                        begin
                            val_next      = ltop_reg;
                            rep_pend_next = 1'b1;
                            rep_heap_next = rmth_pkg::HEAP_LOWER;
                            rep_val_next  = x;
                        end
                        else
                        begin
                            val_next = x;
                        end
                    end
                    else
                    begin
                        heap_next  = rmth_pkg::HEAP_LOWER;
                        idx_next   = lsize_reg[rmth_pkg::IDX_BITS-1:0];
                        lsize_next = lsize_reg + rmth_pkg::SIZE_BITS'(1);
                        if (usize_reg != '0 && x > utop_reg)
                        begin
                            val_next      = utop_reg;
                            rep_pend_next = 1'b1;
                            rep_heap_next = rmth_pkg::HEAP_UPPER;
                            rep_val_next  = x;
                        end
                        else
                        begin
                            val_next = x;
                        end
                    end
                end
            end
            S_PUSH_RD, S_PUSH_EV:
            begin
                rd_addr = rmth_pkg::IDX_BITS'((idx_reg - rmth_pkg::IDX_BITS'(1)) >> 1);
                if (state_reg == S_PUSH_RD && idx_reg != '0)
                begin
                    state_next = S_PUSH_EV;
                end
                else if (state_reg == S_PUSH_EV && rmth_pkg::above(val_reg, rd_data, heap_reg))
                begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    idx_next   = rd_addr;
                    state_next = S_PUSH_RD;
                end
                else
                begin
                    // hole found: place the value and start the replacement if any
                    wr_en = 1'b1;
                    if (rep_pend_reg)
                    begin
                        heap_next     = rep_heap_reg;
                        val_next      = rep_val_reg;
                        idx_next      = '0;
                        rsize_next    = (rep_heap_reg == rmth_pkg::HEAP_LOWER) ?
                                        lsize_reg : usize_reg;
                        rep_pend_next = 1'b0;
                        state_next    = S_DN_RDL;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_DN_RDL:
            begin
                rd_addr = lchild_idx[rmth_pkg::IDX_BITS-1:0];
                if (lchild_idx >= CHILD_BITS'(rsize_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                lchild_next = rd_data;
                rd_addr     = rchild_idx[rmth_pkg::IDX_BITS-1:0];
                has_r_next  = (rchild_idx < CHILD_BITS'(rsize_reg));
                state_next  = S_DN_EV;
            end
            S_DN_EV:
            begin
                wr_en = 1'b1;
                if (rmth_pkg::above(best_val, val_reg, heap_reg))
                begin
                    wr_data    = best_val;
                    idx_next   = best_idx;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (lsize_reg > usize_reg)
                begin
                    last_med_next = {ltop_reg, 1'b0};
                end
                else if (lsize_reg != '0)
                begin
                    last_med_next = rmth_pkg::MED_BITS'(ltop_reg) + rmth_pkg::MED_BITS'(utop_reg);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_med_next   = last_med_reg;
                    out_cnt_next   = count;
                    out_drop_next  = drop_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // mirror of the heap roots
    always_comb
    begin
        ltop_next = ltop_reg;
        utop_next = utop_reg;
        if (wr_en && wr_addr == '0)
        begin
            if (heap_reg == rmth_pkg::HEAP_LOWER)
            begin
                ltop_next = wr_data;
            end
            else
            begin
                utop_next = wr_data;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lsize_reg     <= '0;
            usize_reg     <= '0;
            last_med_reg  <= '0;
            out_valid_reg <= 1'b0;
            rep_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lsize_reg     <= lsize_next;
            usize_reg     <= usize_next;
            last_med_reg  <= last_med_next;
            out_valid_reg <= out_valid_next;
            rep_pend_reg  <= rep_pend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ltop_reg     <= ltop_next;
        utop_reg     <= utop_next;
        heap_reg     <= heap_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        rsize_reg    <= rsize_next;
        rep_heap_reg <= rep_heap_next;
        rep_val_reg  <= rep_val_next;
        lchild_reg   <= lchild_next;
        has_r_reg    <= has_r_next;
        drop_reg     <= drop_next;
        out_med_reg  <= out_med_next;
        out_cnt_reg  <= out_cnt_next;
        out_drop_reg <= out_drop_next;
    end

`ifndef NO_ASSERTIONS
    // heaps stay balanced
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (lsize_reg == usize_reg) || (lsize_reg == usize_reg + rmth_pkg::SIZE_BITS'(1)))
        else $error("heap sizes out of balance");

    // held samples never exceed capacity
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count <= rmth_pkg::CNT_BITS'(rmth_pkg::CAPACITY))
        else $error("sample count above capacity");

    // an accepted request blocks the next one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall)
        else $error("request accepted while busy");

    // a dropped result repeats the stored median
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && drop_reg && (!out_valid_reg || !out_stall))
        |=> (out_med_reg == last_med_reg && out_drop_reg))
        else $error("dropped request changed the median");
`endif

endmodule
